>>> rtl/hss_pkg.sv
package hss_pkg;

    localparam int MAX_WIDTH   = 1024;
    localparam int ADDR_W      = $clog2(MAX_WIDTH);
    localparam int ROW_WIDTH_W = 11;
    // wide enough for row_width and for a column count that reaches MAX_WIDTH
    localparam int WID_W       = (ADDR_W + 1 > ROW_WIDTH_W) ? ADDR_W + 1 : ROW_WIDTH_W;

    localparam int PIX_W       = 8;
    localparam int GAIN_W      = 16;
    localparam int SHADE_W     = 13;
    localparam int FRAC_W      = 12;
    localparam int SHADE_ONE   = 4096;
    localparam int CHAN_MAX    = 255;

    // (9-bit signed diff) * (17-bit signed gain) plus headroom for 1.0 minus it
    localparam int RAW_W       = PIX_W + GAIN_W + 3;
    localparam int CH_PROD_W   = PIX_W + SHADE_W;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_ROW_WIDTH     = 3'd0,
        CFG_OFFSET_X      = 3'd1,
        CFG_OFFSET_Z      = 3'd2,
        CFG_SLOPE_GAIN    = 3'd3,
        CFG_SHADE_FLOOR   = 3'd4,
        CFG_SHADE_CEILING = 3'd5
    } cfg_index_t;

    localparam logic [ROW_WIDTH_W-1:0] ROW_WIDTH_RST     = ROW_WIDTH_W'(256);
    localparam logic [GAIN_W-1:0]      SLOPE_GAIN_RST    = GAIN_W'(164);
    localparam logic [SHADE_W-1:0]     SHADE_FLOOR_RST   = SHADE_W'(410);
    localparam logic [SHADE_W-1:0]     SHADE_CEILING_RST = SHADE_W'(4096);

    typedef struct packed {
        logic               offset_x;
        logic               offset_z;
        logic [GAIN_W-1:0]  slope_gain;
        logic [SHADE_W-1:0] shade_floor;
        logic [SHADE_W-1:0] shade_ceiling;
    } cfg_t;

    typedef struct packed {
        logic [PIX_W-1:0] height;
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
        logic             col_nonzero;
        logic             past_first_row;
    } pixel_t;

endpackage

>>> rtl/hss_line_store.sv
module hss_line_store (
    input  logic                       clk,
    input  logic                       en,
    input  logic [hss_pkg::ADDR_W-1:0] addr,
    input  logic [hss_pkg::PIX_W-1:0]  wdata,
    output logic [hss_pkg::PIX_W-1:0]  rdata
);

    logic [hss_pkg::PIX_W-1:0] mem [hss_pkg::MAX_WIDTH];

    // read returns the entry as it was before this beat's write
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rdata      <= mem[addr];
            mem[addr]  <= wdata;
        end
    end

endmodule

>>> rtl/hss_shade_pipe.sv
module hss_shade_pipe (
    input  logic                       clk,
    input  logic                       rst_n,
    input  hss_pkg::cfg_t              cfg,
    input  logic                       pix_valid,
    input  hss_pkg::pixel_t            pix,
    input  logic [hss_pkg::PIX_W-1:0]  above,
    output logic                       advance,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [hss_pkg::PIX_W-1:0]  red_out,
    output logic [hss_pkg::PIX_W-1:0]  green_out,
    output logic [hss_pkg::PIX_W-1:0]  blue_out,
    output logic [hss_pkg::SHADE_W-1:0] shade_value
);

    localparam int RAW_W = hss_pkg::RAW_W;
    localparam int CPW   = hss_pkg::CH_PROD_W;
    localparam int PW    = hss_pkg::PIX_W;

    logic [PW-1:0] left_height_reg, upper_left_height_reg;

    logic                    v2_reg, v3_reg, out_valid_reg;
    logic signed [RAW_W-1:0] raw_reg;
    logic [PW-1:0]           r2_reg, g2_reg, b2_reg;
    logic [CPW-1:0]          rp_reg, gp_reg, bp_reg;
    logic [hss_pkg::SHADE_W-1:0] shade3_reg;

    logic [PW-1:0]                 red_reg, green_reg, blue_reg;
    logic [hss_pkg::SHADE_W-1:0]   shade_reg;

    logic [PW-1:0]                 nb;
    logic                          has_nb;
    logic signed [PW:0]            diff;
    logic signed [hss_pkg::GAIN_W:0] gain_s;
    logic signed [RAW_W-1:0]       prod;
    logic signed [RAW_W-1:0]       raw_next;
    logic signed [RAW_W-1:0]       floored;
    logic signed [RAW_W-1:0]       clamped;
    logic [hss_pkg::SHADE_W-1:0]   shade_next;
    logic [PW:0]                   rs, gs, bs;

    assign advance = !out_valid_reg || out_ready;

    // neighbour toward the light
    always_comb
    begin
        case ({cfg.offset_x, cfg.offset_z})
            2'b11:   nb = upper_left_height_reg;
            2'b10:   nb = left_height_reg;
            2'b01:   nb = above;
            default: nb = pix.height;
        endcase
        has_nb   = (!cfg.offset_z || pix.past_first_row) && (!cfg.offset_x || pix.col_nonzero);
        diff     = $signed({1'b0, nb}) - $signed({1'b0, pix.height});
        gain_s   = $signed({1'b0, cfg.slope_gain});
        prod     = diff * gain_s;
        raw_next = $signed(RAW_W'(hss_pkg::SHADE_ONE));
        if (has_nb)
        begin
            raw_next = $signed(RAW_W'(hss_pkg::SHADE_ONE)) - prod;
        end
    end

    // raise to floor first, then lower to ceiling
    always_comb
    begin
        floored = raw_reg;
        if (raw_reg < $signed(RAW_W'(cfg.shade_floor)))
        begin
            floored = $signed(RAW_W'(cfg.shade_floor));
        end
        clamped = floored;
        if (floored > $signed(RAW_W'(cfg.shade_ceiling)))
        begin
            clamped = $signed(RAW_W'(cfg.shade_ceiling));
        end
        shade_next = clamped[hss_pkg::SHADE_W-1:0];
    end

    assign rs = rp_reg[CPW-1:hss_pkg::FRAC_W];
    assign gs = gp_reg[CPW-1:hss_pkg::FRAC_W];
    assign bs = bp_reg[CPW-1:hss_pkg::FRAC_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg                <= 1'b0;
            v3_reg                <= 1'b0;
            out_valid_reg         <= 1'b0;
            left_height_reg       <= '0;
            upper_left_height_reg <= '0;
        end
        else if (advance)
        begin
            v2_reg        <= pix_valid;
            v3_reg        <= v2_reg;
            out_valid_reg <= v3_reg;
            if (pix_valid)
            begin
                left_height_reg       <= pix.height;
                upper_left_height_reg <= above;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            raw_reg    <= raw_next;
            r2_reg     <= pix.red;
            g2_reg     <= pix.green;
            b2_reg     <= pix.blue;
            shade3_reg <= shade_next;
            rp_reg     <= CPW'(r2_reg) * CPW'(shade_next);
            gp_reg     <= CPW'(g2_reg) * CPW'(shade_next);
            bp_reg     <= CPW'(b2_reg) * CPW'(shade_next);
            shade_reg  <= shade3_reg;
            red_reg    <= (rs > (PW+1)'(hss_pkg::CHAN_MAX)) ? PW'(hss_pkg::CHAN_MAX) : rs[PW-1:0];
            green_reg  <= (gs > (PW+1)'(hss_pkg::CHAN_MAX)) ? PW'(hss_pkg::CHAN_MAX) : gs[PW-1:0];
            blue_reg   <= (bs > (PW+1)'(hss_pkg::CHAN_MAX)) ? PW'(hss_pkg::CHAN_MAX) : bs[PW-1:0];
        end
    end

    assign out_valid   = out_valid_reg;
    assign red_out     = red_reg;
    assign green_out   = green_reg;
    assign blue_out    = blue_reg;
    assign shade_value = shade_reg;

endmodule

>>> rtl/heightmap_slope_shader_top.sv
// Slope shader for a raster pixel stream: takes one pixel per clock (height byte plus RGB)
// and returns one shaded pixel with its Q1.12 shade via the input, raw-shade, product and
// output registers, sustaining one pixel per clock while out_ready stays high. The rate
// is set by the single-port line store of previous-row heights, read and written once per
// pixel at the current column; the pipeline stalls as a whole when the output register is
// full and not taken. The line store has no clearing pass; entries are used only past a
// frame's first row. cfg_ready is always high; write registers only while idle.
module heightmap_slope_shader_top (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [hss_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [hss_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic                               frame_start,
    input  logic [hss_pkg::PIX_W-1:0]          height_sample,
    input  logic [hss_pkg::PIX_W-1:0]          red_in,
    input  logic [hss_pkg::PIX_W-1:0]          green_in,
    input  logic [hss_pkg::PIX_W-1:0]          blue_in,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [hss_pkg::PIX_W-1:0]          red_out,
    output logic [hss_pkg::PIX_W-1:0]          green_out,
    output logic [hss_pkg::PIX_W-1:0]          blue_out,
    output logic [hss_pkg::SHADE_W-1:0]        shade_value
);

    localparam int AW = hss_pkg::ADDR_W;
    localparam int WW = hss_pkg::WID_W;

    logic [hss_pkg::ROW_WIDTH_W-1:0] row_width_reg;
    hss_pkg::cfg_t                   cfg_reg;

    logic [AW-1:0]   column_count_reg;
    logic            past_first_row_reg;
    logic            pix_valid_reg;
    hss_pkg::pixel_t pix_reg;

    logic            advance;
    logic            accept;
    logic [WW-1:0]   width_ext, width_eff;
    logic [AW-1:0]   col;
    logic            pfr;
    logic [WW-1:0]   col_inc;
    logic [AW-1:0]   column_count_next;
    logic            past_first_row_next;
    logic [hss_pkg::PIX_W-1:0] above;

    assign cfg_ready = 1'b1;
    assign in_ready  = advance;
    assign accept    = in_valid && advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_width_reg         <= hss_pkg::ROW_WIDTH_RST;
            cfg_reg.offset_x      <= 1'b1;
            cfg_reg.offset_z      <= 1'b1;
            cfg_reg.slope_gain    <= hss_pkg::SLOPE_GAIN_RST;
            cfg_reg.shade_floor   <= hss_pkg::SHADE_FLOOR_RST;
            cfg_reg.shade_ceiling <= hss_pkg::SHADE_CEILING_RST;
        end
        else if (cfg_valid)
        begin
            case (hss_pkg::cfg_index_t'(cfg_index))
                hss_pkg::CFG_ROW_WIDTH:
                    row_width_reg <= cfg_data[hss_pkg::ROW_WIDTH_W-1:0];
                hss_pkg::CFG_OFFSET_X:
                    cfg_reg.offset_x <= cfg_data[0];
                hss_pkg::CFG_OFFSET_Z:
                    cfg_reg.offset_z <= cfg_data[0];
                hss_pkg::CFG_SLOPE_GAIN:
                    cfg_reg.slope_gain <= cfg_data[hss_pkg::GAIN_W-1:0];
                hss_pkg::CFG_SHADE_FLOOR:
                    cfg_reg.shade_floor <= cfg_data[hss_pkg::SHADE_W-1:0];
                hss_pkg::CFG_SHADE_CEILING:
                    cfg_reg.shade_ceiling <= cfg_data[hss_pkg::SHADE_W-1:0];
                default: ;
            endcase
        end
    end

    // clamp the row width to 1..MAX_WIDTH
    always_comb
    begin
        width_ext = WW'(row_width_reg);
        width_eff = width_ext;
        if (width_ext == '0)
        begin
            width_eff = WW'(1);
        end
        else if (width_ext > WW'(hss_pkg::MAX_WIDTH))
        begin
            width_eff = WW'(hss_pkg::MAX_WIDTH);
        end
    end

    always_comb
    begin
        col = frame_start ? '0 : column_count_reg;
        pfr = frame_start ? 1'b0 : past_first_row_reg;
        // width shrunk under the position: start a new row
        if (WW'(col) >= width_eff)
        begin
            col = '0;
            pfr = 1'b1;
        end
        col_inc             = WW'(col) + WW'(1);
        column_count_next   = col_inc[AW-1:0];
        past_first_row_next = pfr;
        if (col_inc >= width_eff)
        begin
            column_count_next   = '0;
            past_first_row_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_count_reg   <= '0;
            past_first_row_reg <= 1'b0;
            pix_valid_reg      <= 1'b0;
        end
        else if (advance)
        begin
            pix_valid_reg <= in_valid;
            if (in_valid)
            begin
                column_count_reg   <= column_count_next;
                past_first_row_reg <= past_first_row_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pix_reg.height         <= height_sample;
            pix_reg.red            <= red_in;
            pix_reg.green          <= green_in;
            pix_reg.blue           <= blue_in;
            pix_reg.col_nonzero    <= (col != '0);
            pix_reg.past_first_row <= pfr;
        end
    end

    hss_line_store u_line_store (
        .clk   (clk),
        .en    (accept),
        .addr  (col),
        .wdata (height_sample),
        .rdata (above)
    );

    hss_shade_pipe u_shade_pipe (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .pix_valid   (pix_valid_reg),
        .pix         (pix_reg),
        .above       (above),
        .advance     (advance),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .red_out     (red_out),
        .green_out   (green_out),
        .blue_out    (blue_out),
        .shade_value (shade_value)
    );

endmodule
